FILE: design/rgbak_pkg.sv
// ----------------------------------------------------------------------------
// rgbak_pkg
// Shared types and constants of the RGBA kernel convolution block.
// ----------------------------------------------------------------------------
package rgbak_pkg;

	localparam int CMD_W        = 2;
	localparam int IDX_W        = 5;
	localparam int BYTE_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 14;
	localparam int CFGW_W       = 11;
	localparam int CFGH_W       = 13;
	localparam int K_W          = 3;
	localparam int DIVREG_W     = 14;
	localparam int ROW_W        = 12;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int IDENT_TAP    = 4;
	localparam int BIAS_ZERO    = 128;
	localparam int BYTE_MAX     = 255;
	localparam int PROD_W       = 17;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_PIXEL  = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH     = 3'd0,
		REG_HEIGHT    = 3'd1,
		REG_KSIZE     = 3'd2,
		REG_DIVISOR   = 3'd3,
		REG_THRESHOLD = 3'd4,
		REG_EDGE_DIV  = 3'd5,
		REG_INC_ALPHA = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_TAP,
		ST_FLUSH,
		ST_DIVSET,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

FILE: design/rgbak_ram.sv
// ----------------------------------------------------------------------------
// rgbak_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbak_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/rgba_kernel_convolution.sv
// ----------------------------------------------------------------------------
// rgba_kernel_convolution
// Streaming 2D convolution of a raster RGBA8 frame with an odd square kernel.
// ----------------------------------------------------------------------------
// Flow: a pixel or flush word that yields a result passes ST_CHECK, ST_TAP,
//   ST_FLUSH, ST_DIVSET, ST_DIV and ST_DONE; a zero divisor skips the divide steps.
//   The block takes no new pixel or flush word until the last one is through,
//   and an output stall holds it in ST_DONE; the single tap MAC does one kernel tap
//   a cycle and the bit-serial divider one quotient bit a cycle; a coefficient load
//   or an unused word does not make the block busy, and a pixel or flush word with
//   no result returns to idle from ST_CHECK.
// Reset: async, active low; registers take their reset values, kernel is
//   identity, the line store is left as is and never read before written.
module rgba_kernel_convolution #(
	parameter int MAX_KERNEL = 5,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rgbak_pkg::CMD_W-1:0]          command,
	input  logic [rgbak_pkg::IDX_W-1:0]          coef_index,
	input  logic signed [rgbak_pkg::BYTE_W-1:0]  coef_value,
	input  logic [rgbak_pkg::BYTE_W-1:0]         in_red,
	input  logic [rgbak_pkg::BYTE_W-1:0]         in_green,
	input  logic [rgbak_pkg::BYTE_W-1:0]         in_blue,
	input  logic [rgbak_pkg::BYTE_W-1:0]         in_alpha,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rgbak_pkg::BYTE_W-1:0]         out_red,
	output logic [rgbak_pkg::BYTE_W-1:0]         out_green,
	output logic [rgbak_pkg::BYTE_W-1:0]         out_blue,
	output logic [rgbak_pkg::BYTE_W-1:0]         out_alpha,
	output logic                                 frame_end,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rgbak_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgbak_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rgbak_pkg::*;

	localparam int RING_ROWS = MAX_KERNEL + 1;
	localparam int TAPS      = MAX_KERNEL * MAX_KERNEL;
	localparam int TAP_W     = $clog2(TAPS);
	localparam int IDXE_W    = (TAP_W > IDX_W) ? TAP_W : IDX_W;
	localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int SLOT_W    = $clog2(RING_ROWS);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int W_W       = $clog2(MAX_WIDTH + 1);
	localparam int ACC_W     = PROD_W + $clog2(TAPS);
	localparam int CSUM_W    = BYTE_W + $clog2(TAPS);
	localparam int DIV_W     = (CSUM_W > DIVREG_W) ? CSUM_W : DIVREG_W;
	localparam int CNT_W     = $clog2(ACC_W + 1);
	localparam int TY_W      = ROW_W + 2;
	localparam int TX_W      = COL_W + 2;
	localparam int RES_W     = ACC_W + 2;

	// ---------------- state ----------------
	state_t state_q, state_d;

	logic [CFGW_W-1:0]          width_q;
	logic [CFGH_W-1:0]          height_q;
	logic [K_W-1:0]             ksize_q;
	logic signed [DIVREG_W-1:0] divisor_q;
	logic [BYTE_W-1:0]          thresh_q;
	logic                       edge_div_q;
	logic                       inc_alpha_q;

	logic signed [BYTE_W-1:0] kernel_q [TAPS];

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic              frame_rcv_q;
	logic              out_valid_q;
	logic              rd_s1;

	// tap walk and arithmetic (no reset)
	logic [K_W-1:0]             i_q, j_q;
	logic [TAP_W-1:0]           tap_q;
	logic signed [TY_W-1:0]     ty_q;
	logic signed [TX_W-1:0]     tx_q;
	logic [SLOT_W-1:0]          tslot_q;
	logic                       cen_s1;
	logic signed [BYTE_W-1:0]   coef_s1;
	logic signed [ACC_W-1:0]    acc_q [4];
	logic signed [CSUM_W-1:0]   csum_q;
	logic                       full_q;
	logic [BYTE_W-1:0]          cen_alpha_q;
	logic [ACC_W-1:0]           num_q [4];
	logic                       neg_q [4];
	logic [DIV_W-1:0]           rem_q [4];
	logic [DIV_W-1:0]           den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [BYTE_W-1:0]          res_q [4];
	logic                       fend_q;

	// ---------------- effective geometry ----------------
	logic [W_W-1:0]    eff_w;
	logic [CFGH_W-1:0] eff_h;
	logic [K_W-1:0]    rad;

	always_comb begin
		if (width_q == '0) begin
			eff_w = W_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = W_W'(MAX_WIDTH);
		end else begin
			eff_w = W_W'(width_q);
		end
		if (height_q == '0) begin
			eff_h = CFGH_W'(1);
		end else if (int'(height_q) > HEIGHT_LIMIT) begin
			eff_h = CFGH_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = height_q;
		end
	end
	assign rad = ksize_q >> 1;

	// ---------------- handshakes ----------------
	logic in_acc, cfg_acc, out_take, done_go;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_take  = out_valid_q && !out_stall;
	assign done_go   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// ---------------- line store ----------------
	logic              pix_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0]       wdata, rdata;

	assign pix_we = in_acc && (command == CMD_PIXEL) && !frame_rcv_q
		&& ((W_W+1)'(in_col_q) < (W_W+1)'(eff_w))
		&& ((CFGH_W+1)'(in_row_q) < (CFGH_W+1)'(eff_h));
	assign waddr  = ADDR_W'(in_slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);
	assign wdata  = {in_red, in_green, in_blue, in_alpha};
	assign raddr  = ADDR_W'(tslot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tx_q[COL_W-1:0]);

	rgbak_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (pix_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------- output position checks ----------------
	logic out_oob, avail, tap_in, tap_last, row_last;
	logic [CFGH_W:0] ny;
	logic [W_W:0]    nx;

	always_comb begin
		out_oob = ((W_W+1)'(out_col_q) >= (W_W+1)'(eff_w))
			|| ((CFGH_W+1)'(out_row_q) >= (CFGH_W+1)'(eff_h));
		ny = (CFGH_W+1)'(out_row_q) + (CFGH_W+1)'(rad);
		if (ny > (CFGH_W+1)'(eff_h) - 1'b1) begin
			ny = (CFGH_W+1)'(eff_h) - 1'b1;
		end
		nx = (W_W+1)'(out_col_q) + (W_W+1)'(rad);
		if (nx > (W_W+1)'(eff_w) - 1'b1) begin
			nx = (W_W+1)'(eff_w) - 1'b1;
		end
		// input position strictly past the newest source pixel this output needs
		avail = ((CFGH_W+1)'(in_row_q) > ny)
			|| (((CFGH_W+1)'(in_row_q) == ny) && ((W_W+1)'(in_col_q) > nx));
		tap_in = (ty_q >= 0) && (ty_q < $signed(TY_W'(eff_h)))
			&& (tx_q >= 0) && (tx_q < $signed(TX_W'(eff_w)));
		row_last = (j_q == ksize_q - 1'b1);
		tap_last = row_last && (i_q == ksize_q - 1'b1);
	end

	// ---------------- divisor select ----------------
	logic signed [DIV_W-1:0] div_sel;
	assign div_sel = (!full_q && edge_div_q) ? DIV_W'(csum_q) : DIV_W'(divisor_q);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (command == CMD_PIXEL || command == CMD_FLUSH)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (out_oob || (!frame_rcv_q && !avail)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_TAP;
				end
			end
			ST_TAP: begin
				if (tap_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH:  state_d = ST_DIVSET;
			ST_DIVSET: state_d = (div_sel == '0) ? ST_DONE : ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (done_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- registers, counters, kernel ----------------
	logic cfg_restart, ks_ok;
	logic [K_W-1:0]    ks_new;
	logic [IDXE_W-1:0] cidx;

	assign ks_new = cfg_data[K_W-1:0];
	assign ks_ok  = ks_new[0] && (ks_new >= K_W'(3)) && (int'(ks_new) <= MAX_KERNEL);
	assign cfg_restart = cfg_acc && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT)
		|| ((cfg_index == REG_KSIZE) && ks_ok));
	assign cidx = IDXE_W'(coef_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFGW_W'(256);
			height_q    <= CFGH_W'(256);
			ksize_q     <= K_W'(3);
			divisor_q   <= DIVREG_W'(1);
			thresh_q    <= BYTE_W'(BIAS_ZERO);
			edge_div_q  <= 1'b1;
			inc_alpha_q <= 1'b0;
			for (int t = 0; t < TAPS; t++) begin
				kernel_q[t] <= (t == IDENT_TAP) ? BYTE_W'(1) : '0;
			end
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			frame_rcv_q <= 1'b0;
			out_valid_q <= 1'b0;
			rd_s1       <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_TAP) && tap_in;

			// configuration words
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_WIDTH:     width_q     <= cfg_data[CFGW_W-1:0];
					REG_HEIGHT:    height_q    <= cfg_data[CFGH_W-1:0];
					REG_KSIZE:     if (ks_ok) ksize_q <= ks_new;
					REG_DIVISOR:   divisor_q   <= cfg_data[DIVREG_W-1:0];
					REG_THRESHOLD: thresh_q    <= cfg_data[BYTE_W-1:0];
					REG_EDGE_DIV:  edge_div_q  <= cfg_data[0];
					REG_INC_ALPHA: inc_alpha_q <= cfg_data[0];
					REG_NONE:      ;
					default:       ;
				endcase
			end

			// coefficient load; drop indexes past the kernel store
			if (in_acc && command == CMD_LOAD && int'(cidx) < TAPS) begin
				kernel_q[cidx[TAP_W-1:0]] <= coef_value;
			end

			// output handshake: a new word replaces the one taken this cycle
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			// restart the frame: geometry write, stale position, or last output
			if (cfg_restart || (state_q == ST_CHECK && out_oob) || (done_go && fend_q)) begin
				in_col_q    <= '0;
				in_row_q    <= '0;
				in_slot_q   <= '0;
				out_col_q   <= '0;
				out_row_q   <= '0;
				out_slot_q  <= '0;
				frame_rcv_q <= 1'b0;
			end else begin
				// advance the input raster position
				if (pix_we) begin
					if ((W_W+1)'(in_col_q) + 1'b1 < (W_W+1)'(eff_w)) begin
						in_col_q <= in_col_q + 1'b1;
					end else if ((CFGH_W+1)'(in_row_q) + 1'b1 < (CFGH_W+1)'(eff_h)) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= (int'(in_slot_q) == RING_ROWS - 1) ? '0 : in_slot_q + 1'b1;
					end else begin
						in_col_q    <= '0;
						in_row_q    <= '0;
						in_slot_q   <= '0;
						frame_rcv_q <= 1'b1;
					end
				end

				// advance the output raster position
				if (done_go) begin
					if ((W_W+1)'(out_col_q) + 1'b1 < (W_W+1)'(eff_w)) begin
						out_col_q <= out_col_q + 1'b1;
					end else if ((CFGH_W+1)'(out_row_q) + 1'b1 < (CFGH_W+1)'(eff_h)) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + 1'b1;
						out_slot_q <= (int'(out_slot_q) == RING_ROWS - 1) ? '0 : out_slot_q + 1'b1;
					end
				end
			end
		end
	end

	// ---------------- tap walk, MAC and divider ----------------
	logic [SLOT_W:0] slot_start;
	assign slot_start = (SLOT_W+1)'(out_slot_q) + (SLOT_W+1)'(RING_ROWS) - (SLOT_W+1)'(rad);

	logic signed [ACC_W:0]   qv [4];
	logic signed [RES_W-1:0] rsum [4];
	logic signed [9:0]       bias;
	logic [BYTE_W-1:0]       clamped [4];
	logic [DIV_W:0]          trial [4];

	always_comb begin
		bias = $signed({2'b00, thresh_q}) - 10'sd128;
		for (int c = 0; c < 4; c++) begin
			qv[c]   = neg_q[c] ? -$signed({1'b0, num_q[c]}) : $signed({1'b0, num_q[c]});
			rsum[c] = RES_W'(qv[c]) + RES_W'(bias);
			if (rsum[c] > RES_W'(BYTE_MAX)) begin
				clamped[c] = BYTE_W'(BYTE_MAX);
			end else if (rsum[c] < 0) begin
				clamped[c] = '0;
			end else begin
				clamped[c] = rsum[c][BYTE_W-1:0];
			end
			trial[c] = {rem_q[c], num_q[c][ACC_W-1]};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CHECK: begin
				i_q     <= '0;
				j_q     <= '0;
				tap_q   <= '0;
				ty_q    <= TY_W'(out_row_q) - TY_W'(rad);
				tx_q    <= TX_W'(out_col_q) - TX_W'(rad);
				tslot_q <= (slot_start >= (SLOT_W+1)'(RING_ROWS))
					? SLOT_W'(slot_start - (SLOT_W+1)'(RING_ROWS)) : SLOT_W'(slot_start);
				csum_q  <= '0;
				full_q  <= 1'b1;
				fend_q  <= 1'b0;
				for (int c = 0; c < 4; c++) begin
					acc_q[c] <= '0;
				end
			end
			ST_TAP: begin
				coef_s1 <= kernel_q[tap_q];
				cen_s1  <= (i_q == rad) && (j_q == rad);
				if (tap_in) begin
					csum_q <= csum_q + CSUM_W'(kernel_q[tap_q]);
				end else begin
					full_q <= 1'b0;
				end
				tap_q <= tap_q + 1'b1;
				if (row_last) begin
					j_q     <= '0;
					i_q     <= i_q + 1'b1;
					tx_q    <= TX_W'(out_col_q) - TX_W'(rad);
					ty_q    <= ty_q + 1'b1;
					tslot_q <= (int'(tslot_q) == RING_ROWS - 1) ? '0 : tslot_q + 1'b1;
				end else begin
					j_q  <= j_q + 1'b1;
					tx_q <= tx_q + 1'b1;
				end
			end
			ST_DIVSET: begin
				den_q <= (div_sel < 0) ? DIV_W'(-div_sel) : DIV_W'(div_sel);
				cnt_q <= CNT_W'(ACC_W - 1);
				fend_q <= ((W_W+1)'(out_col_q) + 1'b1 >= (W_W+1)'(eff_w))
					&& ((CFGH_W+1)'(out_row_q) + 1'b1 >= (CFGH_W+1)'(eff_h));
				for (int c = 0; c < 4; c++) begin
					num_q[c] <= (acc_q[c] < 0) ? ACC_W'(-acc_q[c]) : ACC_W'(acc_q[c]);
					neg_q[c] <= (acc_q[c] < 0) ^ ((div_sel < 0) && (div_sel != '0));
					rem_q[c] <= '0;
				end
			end
			ST_DIV: begin
				// one quotient bit per cycle on all four channels
				cnt_q <= cnt_q - 1'b1;
				for (int c = 0; c < 4; c++) begin
					if (trial[c] >= (DIV_W+1)'(den_q)) begin
						rem_q[c] <= DIV_W'(trial[c] - (DIV_W+1)'(den_q));
						num_q[c] <= {num_q[c][ACC_W-2:0], 1'b1};
					end else begin
						rem_q[c] <= trial[c][DIV_W-1:0];
						num_q[c] <= {num_q[c][ACC_W-2:0], 1'b0};
					end
				end
			end
			ST_DONE: begin
				if (done_go) begin
					res_q[0] <= clamped[0];
					res_q[1] <= clamped[1];
					res_q[2] <= clamped[2];
					res_q[3] <= inc_alpha_q ? clamped[3] : cen_alpha_q;
				end
			end
			default: ;
		endcase

		// tap MAC, in the cycle after the line store read
		if (rd_s1) begin
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= acc_q[c] + ACC_W'(coef_s1 * $signed({1'b0, rdata[31-8*c -: 8]}));
			end
			if (cen_s1) begin
				cen_alpha_q <= rdata[BYTE_W-1:0];
			end
		end
	end

	logic fend_out_q;
	always_ff @(posedge clk) begin
		if (done_go) begin
			fend_out_q <= fend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = res_q[0];
	assign out_green = res_q[1];
	assign out_blue  = res_q[2];
	assign out_alpha = res_q[3];
	assign frame_end = fend_out_q;
endmodule

FILE: design/rgbak_checker.sv
// ----------------------------------------------------------------------------
// rgbak_checker
// Port-level checks of the convolution block, bound to its top level.
// ----------------------------------------------------------------------------
module rgbak_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [rgbak_pkg::CMD_W-1:0]       command,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [rgbak_pkg::BYTE_W-1:0]      out_red,
	input logic [rgbak_pkg::BYTE_W-1:0]      out_alpha,
	input logic                              frame_end
);
	import rgbak_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_red) && $stable(out_alpha)
			&& $stable(frame_end)))
		else $error("stalled result changed");

	// pixel and flush words start a busy window
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (command == CMD_PIXEL || command == CMD_FLUSH)) |=> in_stall)
		else $error("block not busy after pixel or flush");

	// no result appears the cycle after an accepted word
	a_no_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result too early");

	// a new result is only launched from a busy block
	a_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");
endmodule

bind rgba_kernel_convolution rgbak_checker u_rgbak_checker (.*);
